[rtl/core/apa_pkg.sv]
// ----------------------------------------------------------------------------
// apa_pkg
// shared types and constants of the address pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package apa_pkg;

  localparam int unsigned PoolEntriesDef = 16;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned MaskW  = 32;
  localparam int unsigned LeaseW = 16;
  localparam int unsigned DataW  = AddrW + MaskW + LeaseW;

  typedef enum logic [1:0] {
    FuncLoad    = 2'd0,
    FuncOffer   = 2'd1,
    FuncRelease = 2'd2,
    FuncNone    = 2'd3
  } apa_func_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusNoFree = 2'd1,
    StatusFull   = 2'd2,
    StatusRsvd   = 2'd3
  } apa_status_e;

  // payload of one pool entry
  typedef struct packed {
    logic [LeaseW-1:0] lease;
    logic [MaskW-1:0]  netmask;
    logic [AddrW-1:0]  address;
  } apa_data_t;

  // operation broadcast from the top level to every cell
  typedef struct packed {
    logic      accept;
    apa_func_e func;
    logic      full;
    logic      found;
    apa_data_t data;
  } apa_op_t;

endpackage

`default_nettype wire

[rtl/core/apa_cell.sv]
// ----------------------------------------------------------------------------
// apa_cell
// one pool entry: holds payload and marks, shifts to either neighbour
// ----------------------------------------------------------------------------
`default_nettype none

module apa_cell
  import apa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire apa_op_t   op_i,
  input  wire apa_data_t prev_data_i,
  input  wire logic      prev_busy_i,
  input  wire logic      prev_valid_i,
  input  wire apa_data_t next_data_i,
  input  wire logic      next_busy_i,
  input  wire logic      next_valid_i,
  input  wire apa_data_t picked_i,
  input  wire logic      found_i,
  input  wire apa_data_t pick_data_i,
  output apa_data_t      data_o,
  output logic           busy_o,
  output logic           valid_o,
  output logic           found_o,
  output apa_data_t      pick_data_o
);

  apa_data_t data_q, data_d;
  logic      busy_q, busy_d;
  logic      valid_q, valid_d;
  logic      free;
  logic      last;

  assign free = valid_q & ~busy_q;
  assign last = valid_q & ~next_valid_i;

  // first-free search ripples along the chain
  assign found_o     = found_i | free;
  assign pick_data_o = found_i ? pick_data_i : data_q;

  always_comb begin
    data_d  = data_q;
    busy_d  = busy_q;
    valid_d = valid_q;
    if (op_i.accept) begin
      case (op_i.func)
        FuncLoad: begin
          if (!op_i.full) begin
            data_d  = prev_data_i;
            busy_d  = prev_busy_i;
            valid_d = prev_valid_i;
          end
        end
        FuncOffer: begin
          if (op_i.found) begin
            if (last) begin
              data_d = picked_i;
              busy_d = 1'b1;
            end else if (found_o) begin
              data_d = next_data_i;
              busy_d = next_busy_i;
            end
          end
        end
        FuncRelease: begin
          if (valid_q && data_q.address == op_i.data.address &&
              data_q.netmask == op_i.data.netmask) begin
            busy_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign busy_o  = busy_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

[rtl/core/address_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// address_pool_allocator_core
// ordered address pool with first-free offer, built as a row of entry cells
// ----------------------------------------------------------------------------
// usage
//   slave channel s_axis_*: one transaction per operation, tuser selects load,
//   offer or release; tdata carries address, netmask and lease time
//   master channel m_axis_*: one result transaction per operation, tuser is the
//   status, tdata the offered address, netmask and lease (zero unless an offer
//   succeeded)
//   the result appears in the cycle after the operation is accepted
//   throughput: one operation per cycle while the receiver does not stall;
//   every cell compares its own entry, a ripple through the row finds the
//   first free entry and all cells shift in the same cycle
//   the result sits in an output register; while the receiver stalls with a
//   result held, tready on the slave side drops and the pool stays unchanged
//   reset empties the pool (valid and in-use marks clear at once); entry
//   payloads are not cleared and are never read before they are written
// ----------------------------------------------------------------------------
`default_nettype none

module address_pool_allocator_core
  import apa_pkg::*;
#(
  parameter int unsigned POOL_ENTRIES = PoolEntriesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [DataW-1:0] s_axis_tdata,  // address, netmask, lease_time
  input  wire logic [1:0]       s_axis_tuser,  // func
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [DataW-1:0]      m_axis_tdata,  // offered_address, offered_netmask, offered_lease
  output logic [1:0]            m_axis_tuser   // status
);

  // per-cell signals, one element per cell
  apa_data_t cell_data  [POOL_ENTRIES];
  logic      cell_busy  [POOL_ENTRIES];
  logic      cell_valid [POOL_ENTRIES];
  logic      cell_found [POOL_ENTRIES];
  apa_data_t cell_pick  [POOL_ENTRIES];

  apa_op_t     op;
  apa_func_e   func;
  logic        accept;
  apa_status_e status_d;
  apa_data_t   result_d;

  logic        out_valid_q;
  apa_status_e out_status_q;
  apa_data_t   out_data_q;

  assign func   = apa_func_e'(s_axis_tuser);
  assign accept = s_axis_tvalid & s_axis_tready;

  // a new transaction is taken whenever the output register is free or drains
  assign s_axis_tready = ~out_valid_q | m_axis_tready;

  assign op.accept = accept;
  assign op.func   = func;
  assign op.full   = cell_valid[POOL_ENTRIES-1];           // valid cells stay packed
  assign op.found  = cell_found[POOL_ENTRIES-1];           // end of the search ripple
  assign op.data   = apa_data_t'(s_axis_tdata);

  for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
    apa_data_t prev_data, next_data, pick_in;
    logic      prev_busy, prev_valid, next_busy, next_valid, found_in;

    if (i == 0) begin : g_head
      // a load enters at the front as a free entry
      assign prev_data  = op.data;
      assign prev_busy  = 1'b0;
      assign prev_valid = 1'b1;
      assign found_in   = 1'b0;
      assign pick_in    = '0;
    end else begin : g_body
      assign prev_data  = cell_data[i-1];
      assign prev_busy  = cell_busy[i-1];
      assign prev_valid = cell_valid[i-1];
      assign found_in   = cell_found[i-1];
      assign pick_in    = cell_pick[i-1];
    end

    if (i == POOL_ENTRIES - 1) begin : g_tail
      assign next_data  = '0;
      assign next_busy  = 1'b0;
      assign next_valid = 1'b0;
    end else begin : g_next
      assign next_data  = cell_data[i+1];
      assign next_busy  = cell_busy[i+1];
      assign next_valid = cell_valid[i+1];
    end

    apa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .prev_data_i  (prev_data),
      .prev_busy_i  (prev_busy),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_busy_i  (next_busy),
      .next_valid_i (next_valid),
      .picked_i     (cell_pick[POOL_ENTRIES-1]),
      .found_i      (found_in),
      .pick_data_i  (pick_in),
      .data_o       (cell_data[i]),
      .busy_o       (cell_busy[i]),
      .valid_o      (cell_valid[i]),
      .found_o      (cell_found[i]),
      .pick_data_o  (cell_pick[i])
    );
  end

  // result of the operation being accepted
  always_comb begin
    status_d = StatusOk;
    result_d = '0;
    unique case (func)
      FuncLoad: begin
        if (op.full) status_d = StatusFull;
      end
      FuncOffer: begin
        if (op.found) result_d = cell_pick[POOL_ENTRIES-1];
        else          status_d = StatusNoFree;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status_d;
      out_data_q   <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // valid entries always fill the front of the row without gaps
  for (genvar i = 1; i < POOL_ENTRIES; i++) begin : g_chk_packed
    a_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
      cell_valid[i] |-> cell_valid[i-1])
      else $error("pool entries not packed at the front");
  end

  // a successful load leaves a free entry at the front
  a_load_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FuncLoad && !op.full) |=> (cell_valid[0] && !cell_busy[0]))
    else $error("loaded entry missing at the front");

  // a successful offer on a full pool leaves the last entry in use
  a_offer_full_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FuncOffer && op.found && op.full) |=> cell_busy[POOL_ENTRIES-1])
    else $error("offered entry not moved to the back");

  // each accepted operation yields a result in the next cycle
  a_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted operation produced no result");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the address pool allocator: a pool model in the
// bench predicts the status and offered entry of every operation, the stream
// results are compared field by field under random stalls on both channels
// ----------------------------------------------------------------------------

module tb;
  import apa_pkg::*;

  localparam int unsigned PoolSize    = PoolEntriesDef;
  localparam int          RandomItems = 1180;
  localparam int          CalmItems   = 150;
  localparam int          HoldAt      = 400;
  localparam int          DrainAt     = 700;
  localparam int          LongHold    = 300;
  localparam int          AddrChoices = 6;
  localparam int          CycleLimit  = 200000;

  typedef struct packed {
    logic      busy;
    apa_data_t entry;
  } pool_slot_t;

  typedef struct packed {
    apa_status_e status;
    apa_data_t   data;
  } pool_reply_t;

  // shadow copy of the pool plus the replies still owed by the block
  class pool_tracker;
    pool_slot_t  slots[PoolSize];
    int          count;
    pool_reply_t awaited[$];
    int          errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    task report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    // applies one accepted operation to the shadow pool and queues its reply
    function void note_request(input apa_func_e op, input apa_data_t d);
      pool_reply_t r;
      pool_slot_t  taken;
      int          pick;
      r.status = StatusOk;
      r.data   = '0;
      pick     = -1;
      case (op)
        FuncLoad: begin
          if (count >= PoolSize) begin
            r.status = StatusFull;
          end else begin
            for (int i = count; i > 0; i--) slots[i] = slots[i-1];
            slots[0].entry = d;
            slots[0].busy  = 1'b0;
            count++;
          end
        end
        FuncOffer: begin
          for (int i = 0; i < count; i++) begin
            if (pick < 0 && !slots[i].busy) pick = i;
          end
          if (pick < 0) begin
            r.status = StatusNoFree;
          end else begin
            taken = slots[pick];
            for (int i = pick; i + 1 < count; i++) slots[i] = slots[i+1];
            taken.busy       = 1'b1;
            slots[count-1]   = taken;
            r.data           = taken.entry;
          end
        end
        FuncRelease: begin
          for (int i = 0; i < count; i++) begin
            if (slots[i].entry.address == d.address && slots[i].entry.netmask == d.netmask)
              slots[i].busy = 1'b0;
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    task check_reply(input logic [1:0] status, input apa_data_t d);
      pool_reply_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with no operation outstanding");
      end else begin
        want = awaited.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (d.address !== want.data.address)
          report_mismatch($sformatf("address %h, expected %h", d.address, want.data.address));
        if (d.netmask !== want.data.netmask)
          report_mismatch($sformatf("netmask %h, expected %h", d.netmask, want.data.netmask));
        if (d.lease !== want.data.lease)
          report_mismatch($sformatf("lease %h, expected %h", d.lease, want.data.lease));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata  = '0;  // address, netmask, lease_time
  logic [1:0]       s_axis_tuser  = '0;  // func
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;        // offered_address, offered_netmask, offered_lease
  logic [1:0]       m_axis_tuser;        // status

  pool_tracker tracker = new();
  bit          hold_request = 1'b0;
  bit          calm = 1'b0;
  int          cycle_count = 0;
  logic [31:0] addr_set[AddrChoices];
  logic [31:0] mask_set[AddrChoices];

  address_pool_allocator_core #(
    .POOL_ENTRIES (PoolSize)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result first, then the new transaction, so the queue order is fixed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_reply(m_axis_tuser, apa_data_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_request(apa_func_e'(s_axis_tuser), apa_data_t'(s_axis_tdata));
    end
  end

  // receiver: random stalls, one long hold-off on request, always ready at the end
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_request = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic send_op(input apa_func_e op, input apa_data_t d);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_fields(input apa_func_e op, input logic [31:0] a,
                             input logic [31:0] m, input logic [15:0] l);
    apa_data_t d;
    d.address = a;
    d.netmask = m;
    d.lease   = l;
    send_op(op, d);
  endtask

  task automatic sender_gap(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited.size() != 0) @(posedge clk_i);
  endtask

  // mostly offers and releases of live entries, a few loads from a small
  // address set so that releases hit several entries at once
  task automatic random_item(output bit counted);
    apa_data_t d;
    int        roll;
    int        pick;
    roll      = $urandom_range(0, 99);
    d.address = $urandom;
    d.netmask = $urandom;
    d.lease   = 16'($urandom);
    counted   = 1'b1;
    if (roll < 10) begin
      if ($urandom_range(0, 1) == 1) begin
        pick      = $urandom_range(0, AddrChoices - 1);
        d.address = addr_set[pick];
        d.netmask = mask_set[pick];
      end
      send_op(FuncLoad, d);
    end else if (roll < 55) begin
      send_op(FuncOffer, d);
    end else if (roll < 96) begin
      if (tracker.count > 0 && $urandom_range(0, 99) < 75) begin
        pick      = $urandom_range(0, tracker.count - 1);
        d.address = tracker.slots[pick].entry.address;
        d.netmask = tracker.slots[pick].entry.netmask;
        // near miss: one bit off in either half of the key
        if ($urandom_range(0, 4) == 0) begin
          pick = $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1) d.netmask[pick] = ~d.netmask[pick];
          else                            d.address[pick] = ~d.address[pick];
        end
      end
      send_op(FuncRelease, d);
    end else begin
      send_op(FuncNone, d);
      counted = 1'b0;
    end
  endtask

  initial begin
    int issued;
    int useful;
    bit counted;
    issued = 0;
    useful = 0;
    for (int i = 0; i < AddrChoices; i++) begin
      addr_set[i] = $urandom;
      mask_set[i] = $urandom;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_fields(FuncOffer,   32'h0, 32'h0, 16'h0);                    // offer on empty pool
    send_fields(FuncRelease, 32'h0, 32'h0, 16'h0);                    // release with no entries
    send_fields(FuncNone,    '1, '1, '1);                             // unused code
    send_fields(FuncLoad,    32'h0, 32'h0, 16'h0);
    send_fields(FuncLoad,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_fields(FuncOffer,   32'h0, 32'h0, 16'h0);
    send_fields(FuncOffer,   '1, '1, '1);
    send_fields(FuncOffer,   32'h0, 32'h0, 16'h0);                    // all entries in use
    send_fields(FuncRelease, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0);
    send_fields(FuncRelease, 32'hFFFF_FFFF, 32'h0, 16'h0);            // address only matches
    send_fields(FuncRelease, 32'h0, 32'hFFFF_FFFF, 16'h0);            // netmask only matches
    send_fields(FuncLoad,    32'hC0A8_0001, 32'hFFFF_FF00, 16'd3600);
    send_fields(FuncLoad,    32'hC0A8_0001, 32'hFFFF_FF00, 16'd7200); // duplicate key
    send_fields(FuncOffer,   32'h0, 32'h0, 16'h0);
    send_fields(FuncOffer,   32'h0, 32'h0, 16'h0);
    send_fields(FuncOffer,   32'h0, 32'h0, 16'h0);
    send_fields(FuncRelease, 32'hC0A8_0001, 32'hFFFF_FF00, 16'h0);    // frees both copies
    send_fields(FuncOffer,   32'h0, 32'h0, 16'h0);
    send_fields(FuncNone,    32'h0, 32'h0, 16'h0);
    send_fields(FuncRelease, 32'h0, 32'h0, 16'hFFFF);
    wait_drained();

    // random part
    while (useful < RandomItems) begin
      if (issued == HoldAt) hold_request = 1'b1;
      if (issued == DrainAt) wait_drained();
      if (useful >= RandomItems - CalmItems) calm = 1'b1;
      random_item(counted);
      if (counted) useful++;
      issued++;
      if (!calm && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 16));
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.awaited.size() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.awaited.size()));
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
